// ----- rtl/dsdr_pkg.sv -----
// ----------------------------------------------------------------------------
// dsdr_pkg
// Shared widths, codes and control structs of the set-dueling replacement unit.
// ----------------------------------------------------------------------------
package dsdr_pkg;

  // word field widths
  localparam int OP_W   = 1;
  localparam int SET_W  = 10;
  localparam int WAY_W  = 4;

  // configuration
  localparam int MODE_W = 2;
  localparam int BIPF_W = 6;
  localparam int CNT_W  = 6;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [0:0] REG_POLICY_MODE = 1'b0;
  localparam logic [0:0] REG_BIP_FREQ    = 1'b1;

  localparam logic [MODE_W-1:0] MODE_LRU    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RANDOM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DIP    = 2'd2;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_LRU;
  localparam logic [BIPF_W-1:0] BIPF_RESET = 6'd32;

  localparam logic [OP_W-1:0] OP_QUERY  = 1'b0;
  localparam logic [OP_W-1:0] OP_UPDATE = 1'b1;

  // Galois LFSR
  localparam int                LFSR_W    = 16;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'h0001;

  typedef struct packed {
    logic [MODE_W-1:0] policy_mode;
    logic [BIPF_W-1:0] bip_period;
  } cfg_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_wr;     // write reset row at clear pointer
    logic capture;    // take input word, read its stack row
    logic exec;       // LRU victim out or state update
    logic lfsr_step;  // advance LFSR
    logic rand_mul;   // reciprocal multiply of LFSR
    logic rand_out;   // finish modulo, load random victim
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic is_query;
    logic is_random;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/dsdr_if.sv -----
// ----------------------------------------------------------------------------
// dsdr_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface dsdr_req_if;
  logic                          valid;
  logic                          ready;
  logic [dsdr_pkg::OP_W-1:0]     operation;
  logic [dsdr_pkg::SET_W-1:0]    set_index;
  logic [dsdr_pkg::WAY_W-1:0]    way;
  logic                          hit;

  modport source (output valid, operation, set_index, way, hit, input ready);
  modport sink   (input valid, operation, set_index, way, hit, output ready);
endinterface

interface dsdr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [dsdr_pkg::WAY_W-1:0]    victim_way;
  logic                          follower_uses_bip;

  modport source (output valid, victim_way, follower_uses_bip, input ready);
  modport sink   (input valid, victim_way, follower_uses_bip, output ready);
endinterface

// ----- rtl/dsdr_cfg.sv -----
// ----------------------------------------------------------------------------
// dsdr_cfg
// APB register block: policy mode and BIP insertion frequency.
// ----------------------------------------------------------------------------
module dsdr_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsdr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dsdr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dsdr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  output dsdr_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [0:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[dsdr_pkg::APB_ADDR_W-1];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy_mode <= dsdr_pkg::MODE_RESET;
      cfg.bip_period  <= dsdr_pkg::BIPF_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        dsdr_pkg::REG_POLICY_MODE: cfg.policy_mode <= pwdata[dsdr_pkg::MODE_W-1:0];
        dsdr_pkg::REG_BIP_FREQ:    cfg.bip_period  <= pwdata[dsdr_pkg::BIPF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      dsdr_pkg::REG_POLICY_MODE: prdata = dsdr_pkg::APB_DATA_W'(cfg.policy_mode);
      dsdr_pkg::REG_BIP_FREQ:    prdata = dsdr_pkg::APB_DATA_W'(cfg.bip_period);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ----- rtl/dsdr_ctrl.sv -----
// ----------------------------------------------------------------------------
// dsdr_ctrl
// Sequencer: clear pass, word accept, execute, random-victim modulo steps.
// ----------------------------------------------------------------------------
module dsdr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  dsdr_pkg::status_t  st,
  output dsdr_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_RMUL  = 3'd3;
  localparam logic [2:0] S_RFIN  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (st.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (st.is_query && st.is_random) begin
          cmd.lfsr_step = 1'b1;
          state_next    = S_RMUL;
        end else if (!st.is_query || st.out_free) begin
          // a query waits here until the output register frees up
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RMUL: begin
        cmd.rand_mul = 1'b1;
        state_next   = S_RFIN;
      end
      S_RFIN: begin
        if (st.out_free) begin
          cmd.rand_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR && st.clr_last) |=> (state == S_IDLE))
    else $error("clear pass did not hand over to idle");

endmodule

// ----- rtl/dsdr_dp.sv -----
// ----------------------------------------------------------------------------
// dsdr_dp
// Datapath: LRU stack memory, promote/victim logic, selector, miss counter,
// LFSR with reciprocal modulo, output register.
// ----------------------------------------------------------------------------
module dsdr_dp #(
  parameter int NUM_SETS       = 1024,
  parameter int WAYS           = 16,
  parameter int CONSTITUENCIES = 64,
  parameter int SELECTOR_BITS  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dsdr_pkg::cfg_t                cfg,
  input  dsdr_pkg::cmd_t                cmd,
  output dsdr_pkg::status_t             st,
  input  logic [dsdr_pkg::OP_W-1:0]     req_operation,
  input  logic [dsdr_pkg::SET_W-1:0]    req_set_index,
  input  logic [dsdr_pkg::WAY_W-1:0]    req_way,
  input  logic                          req_hit,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output logic [dsdr_pkg::WAY_W-1:0]    rsp_victim_way,
  output logic                          rsp_follower_uses_bip
);

  function automatic int flog2(input int v);
    int n;
    int x;
    n = 0;
    x = v;
    while (x > 1) begin
      x = x >> 1;
      n++;
    end
    return n;
  endfunction

  localparam int PW        = $clog2(WAYS);
  localparam int SW        = $clog2(NUM_SETS);
  localparam int LOG_SETS  = flog2(NUM_SETS);
  localparam int LOG_CON   = flog2(CONSTITUENCIES);
  localparam int OB        = (LOG_SETS > LOG_CON) ? LOG_SETS - LOG_CON : 0;
  localparam logic [31:0] KIND_MASK = (32'd1 << OB) - 32'd1;
  localparam logic [PW-1:0] BOTTOM  = PW'(WAYS - 1);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
  // quotient of a set index by NUM_SETS (>= 64) fits in this many bits
  localparam int MOD_STEPS = dsdr_pkg::SET_W - 6;
  // floor(2^16 / WAYS): quotient estimate is exact or one low
  localparam logic [16:0] RECIP = 17'(65536 / WAYS);

  typedef logic [WAYS-1:0][PW-1:0] row_t;

  function automatic row_t ident_row();
    row_t r;
    for (int i = 0; i < WAYS; i++) begin
      r[i] = PW'(i);
    end
    return r;
  endfunction

  function automatic row_t promote(input row_t r, input logic [PW-1:0] w);
    row_t o;
    logic [PW-1:0] cur;
    cur = r[w];
    for (int i = 0; i < WAYS; i++) begin
      o[i] = (r[i] < cur) ? r[i] + PW'(1) : r[i];
    end
    o[w] = '0;
    return o;
  endfunction

  function automatic logic [SW-1:0] mod_sets(input logic [dsdr_pkg::SET_W-1:0] idx);
    logic [dsdr_pkg::SET_W-1:0] r;
    r = idx;
    for (int b = MOD_STEPS - 1; b >= 0; b--) begin
      if (32'(r) >= 32'(NUM_SETS << b)) r = r - dsdr_pkg::SET_W'(NUM_SETS << b);
    end
    return SW'(r);
  endfunction

  row_t mem [NUM_SETS];

  row_t                           row_q;
  logic [dsdr_pkg::OP_W-1:0]      op_q;
  logic [SW-1:0]                  set_q;
  logic [dsdr_pkg::WAY_W-1:0]     way_q;
  logic                           hit_q;
  logic [SW-1:0]                  clr_addr;
  logic [SELECTOR_BITS-1:0]       sel;
  logic [dsdr_pkg::CNT_W-1:0]     cnt;
  logic [dsdr_pkg::LFSR_W-1:0]    lfsr;
  logic [dsdr_pkg::LFSR_W-1:0]    lfsr_next;
  logic [31:0]                    prod;
  logic                           out_valid;
  logic [dsdr_pkg::WAY_W-1:0]     out_way;
  logic                           out_msb;

  logic [PW-1:0]                  widx;
  logic                           way_ok;
  logic [PW-1:0]                  lru_idx;
  logic [31:0]                    set32;
  logic [31:0]                    con;
  logic                           is_lru_set;
  logic                           is_bip_set;
  logic [dsdr_pkg::CNT_W:0]       cnt_inc;
  logic [dsdr_pkg::CNT_W-1:0]     cnt_new;
  logic [dsdr_pkg::CNT_W-1:0]     cnt_upd;
  logic [SELECTOR_BITS-1:0]       sel_upd;
  logic                           bip_fire;
  logic                           use_bip;
  logic                           do_prom;
  row_t                           row_new;
  logic                           upd_en;
  logic                           dip_en;
  logic                           lru_load;
  logic                           out_load;
  logic [15:0]                    rand_q;
  logic [15:0]                    rand_qw;
  logic [15:0]                    rand_rem0;
  logic [15:0]                    rand_rem;

  // ---- victim search and update ----
  always_comb begin
    widx   = PW'(way_q);
    way_ok = 32'(way_q) < WAYS;

    lru_idx = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (row_q[i] == BOTTOM) lru_idx = PW'(i);
    end

    // complement selection of dedicated sets
    set32      = 32'(set_q);
    con        = set32 >> OB;
    is_lru_set = (con == (set32 & KIND_MASK));
    is_bip_set = !is_lru_set && (con == (~set32 & KIND_MASK));

    cnt_inc = {1'b0, cnt} + 7'd1;
    if (hit_q) begin
      cnt_new = cnt;
    end else if (cnt_inc > {1'b0, cfg.bip_period}) begin
      cnt_new = '0;
    end else begin
      cnt_new = cnt_inc[dsdr_pkg::CNT_W-1:0];
    end

    bip_fire = hit_q ? (row_q[widx] == BOTTOM) : (cnt_new == cfg.bip_period);

    do_prom = 1'b1;
    use_bip = 1'b0;
    sel_upd = sel;
    cnt_upd = cnt_new;
    if (cfg.policy_mode == dsdr_pkg::MODE_DIP) begin
      if (is_lru_set) begin
        if (!hit_q && sel != SEL_MAX) sel_upd = sel + SELECTOR_BITS'(1);
      end else if (is_bip_set) begin
        if (!hit_q && sel != '0) sel_upd = sel - SELECTOR_BITS'(1);
        use_bip = 1'b1;
      end else begin
        use_bip = sel[SELECTOR_BITS-1];
      end
      if (use_bip) begin
        do_prom = bip_fire;
        // BIP miss that goes to MRU restarts the count
        if (!hit_q && bip_fire) cnt_upd = '0;
      end
    end

    row_new = do_prom ? promote(row_q, widx) : row_q;
  end

  assign upd_en   = cmd.exec && (op_q == dsdr_pkg::OP_UPDATE) && way_ok &&
                    (cfg.policy_mode != dsdr_pkg::MODE_RANDOM);
  assign dip_en   = upd_en && (cfg.policy_mode == dsdr_pkg::MODE_DIP);
  assign lru_load = cmd.exec && (op_q == dsdr_pkg::OP_QUERY);
  assign out_load = lru_load || cmd.rand_out;

  // ---- random victim: lfsr mod WAYS via reciprocal ----
  assign lfsr_next = (lfsr >> 1) ^ (lfsr[0] ? dsdr_pkg::LFSR_TAPS : '0);
  assign rand_q    = prod[31:16];
  assign rand_qw   = 16'(32'(rand_q) * WAYS);
  assign rand_rem0 = lfsr - rand_qw;
  assign rand_rem  = (rand_rem0 >= 16'(WAYS)) ? rand_rem0 - 16'(WAYS) : rand_rem0;

  // ---- stack memory ----
  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      mem[clr_addr] <= ident_row();
    end else if (upd_en) begin
      mem[set_q] <= row_new;
    end
    if (cmd.capture) begin
      row_q <= mem[mod_sets(req_set_index)];
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q  <= req_operation;
      set_q <= mod_sets(req_set_index);
      way_q <= req_way;
      hit_q <= req_hit;
    end
    if (cmd.rand_mul) begin
      prod <= 32'(lfsr) * 32'(RECIP);
    end
    if (out_load) begin
      out_way <= cmd.rand_out ? dsdr_pkg::WAY_W'(rand_rem) : dsdr_pkg::WAY_W'(lru_idx);
      out_msb <= sel[SELECTOR_BITS-1];
    end
  end

  // ---- control state ----
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      sel       <= '0;
      cnt       <= '0;
      lfsr      <= dsdr_pkg::LFSR_SEED;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_addr <= clr_addr + SW'(1);
      if (dip_en) begin
        sel <= sel_upd;
        cnt <= cnt_upd;
      end
      if (cmd.lfsr_step) lfsr <= lfsr_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.clr_last  = (clr_addr == SW'(NUM_SETS - 1));
  assign st.is_query  = (op_q == dsdr_pkg::OP_QUERY);
  assign st.is_random = (cfg.policy_mode == dsdr_pkg::MODE_RANDOM);
  assign st.out_free  = !out_valid || rsp_ready;

  assign rsp_valid             = out_valid;
  assign rsp_victim_way        = out_way;
  assign rsp_follower_uses_bip = out_msb;

  a_lfsr_live: assert property (@(posedge clk) disable iff (rst) lfsr != '0)
    else $error("LFSR locked at zero");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rsp_ready))
    else $error("pending response word overwritten");

  a_rand_range: assert property (@(posedge clk) disable iff (rst)
    cmd.rand_out |-> (32'(rand_rem) < WAYS))
    else $error("random victim outside way range");

endmodule

// ----- rtl/dip_set_dueling_replacement_unit.sv -----
// ----------------------------------------------------------------------------
// dip_set_dueling_replacement_unit
// Replacement unit for a set-associative cache: per-set LRU stacks with true
// LRU, random or DIP set-dueling policy. After reset the unit runs a clearing
// pass that writes every stack row to its initial order; request words are
// not accepted during it, register writes are. Then each word is accepted
// with its stack-row read, then its victim goes out or its row is written
// back; a random-mode victim query steps the LFSR and runs the reciprocal
// modulo before its victim goes out. Queries return one response word each,
// updates return none. A finished response waits in an output register
// while the next request is taken.
// ----------------------------------------------------------------------------
module dip_set_dueling_replacement_unit #(
  parameter int NUM_SETS       = 1024,
  parameter int WAYS           = 16,
  parameter int CONSTITUENCIES = 64,
  parameter int SELECTOR_BITS  = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  dsdr_req_if.sink                          req,
  dsdr_rsp_if.source                        rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dsdr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [dsdr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [dsdr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  dsdr_pkg::cfg_t    cfg;
  dsdr_pkg::cmd_t    cmd;
  dsdr_pkg::status_t st;

  dsdr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsdr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .st        (st),
    .cmd       (cmd)
  );

  dsdr_dp #(
    .NUM_SETS       (NUM_SETS),
    .WAYS           (WAYS),
    .CONSTITUENCIES (CONSTITUENCIES),
    .SELECTOR_BITS  (SELECTOR_BITS)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg                   (cfg),
    .cmd                   (cmd),
    .st                    (st),
    .req_operation         (req.operation),
    .req_set_index         (req.set_index),
    .req_way               (req.way),
    .req_hit               (req.hit),
    .rsp_valid             (rsp.valid),
    .rsp_ready             (rsp.ready),
    .rsp_victim_way        (rsp.victim_way),
    .rsp_follower_uses_bip (rsp.follower_uses_bip)
  );

endmodule

// ----- tb/dip_set_dueling_replacement_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dip_set_dueling_replacement_unit_tb
// Self-checking bench for the set-dueling replacement unit. A short table of
// directed words covers reset order, random-mode LFSR steps, mode three and
// each dedicated-set rule. Random miss/fill and hit traffic then runs under
// every policy setting. Victim words are checked against the fixed word of a
// directed row or an in-bench predictor of stacks, selector, miss counter, LFSR.
// ----------------------------------------------------------------------------
module dip_set_dueling_replacement_unit_tb;

  localparam int NUM_SETS       = 1024;
  localparam int WAYS           = 16;
  localparam int CONSTITUENCIES = 64;
  localparam int SELECTOR_BITS  = 10;

  localparam int MODE_W     = dsdr_pkg::MODE_W;
  localparam int BIPF_W     = dsdr_pkg::BIPF_W;
  localparam int OP_W       = dsdr_pkg::OP_W;
  localparam int SET_W      = dsdr_pkg::SET_W;
  localparam int WAY_W      = dsdr_pkg::WAY_W;
  localparam int APB_ADDR_W = dsdr_pkg::APB_ADDR_W;
  localparam int APB_DATA_W = dsdr_pkg::APB_DATA_W;
  localparam int LFSR_W     = dsdr_pkg::LFSR_W;

  // unnamed encoding, decodes as true LRU
  localparam logic [MODE_W-1:0] MODE_LRU_ALIAS = 2'd3;

  localparam logic [APB_ADDR_W-1:0] ADDR_POLICY_MODE = {dsdr_pkg::REG_POLICY_MODE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_BIP_FREQ    = {dsdr_pkg::REG_BIP_FREQ, 2'b00};

  localparam int                       DUEL_SHIFT = $clog2(NUM_SETS) - $clog2(CONSTITUENCIES);
  localparam logic [SET_W-1:0]         DUEL_MASK  = SET_W'((1 << DUEL_SHIFT) - 1);
  localparam logic [SELECTOR_BITS-1:0] SEL_MAX    = '1;
  // selector level at which an upward push stops: just past the MSB flip
  localparam int                       PUSH_TARGET = 530;
  localparam int                       SETTLE_CYCLES = 10;

  typedef enum logic [1:0] {FOLLOWER, DEDICATED_LRU, DEDICATED_BIP} set_kind_e;
  typedef enum logic [1:0] {DRIFT_NONE, DRIFT_UP, DRIFT_DOWN} drift_e;
  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             follower_uses_bip;
  } victim_word_t;

  typedef struct {
    row_kind_e         kind;
    logic [MODE_W-1:0] mode;
    logic [BIPF_W-1:0] bipf;
    logic [OP_W-1:0]   op;
    logic [SET_W-1:0]  set_idx;
    logic [WAY_W-1:0]  way;
    logic              hit;
    bit                known;
    victim_word_t      want;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dsdr_req_if req_ch ();
  dsdr_rsp_if rsp_ch ();

  dip_set_dueling_replacement_unit #(
    .NUM_SETS      (NUM_SETS),
    .WAYS          (WAYS),
    .CONSTITUENCIES(CONSTITUENCIES),
    .SELECTOR_BITS (SELECTOR_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .req    (req_ch),
    .rsp    (rsp_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor state
  logic [WAY_W-1:0]         lru_rank [NUM_SETS][WAYS];
  logic [SELECTOR_BITS-1:0] duel_selector;
  int                       miss_count;
  logic [LFSR_W-1:0]        victim_lfsr;
  logic [MODE_W-1:0]        cur_mode;
  logic [BIPF_W-1:0]        cur_bipf;

  victim_word_t     pending_victims [$];
  stim_row_t        directed_rows [$];
  logic [SET_W-1:0] follower_pool [8];
  logic [WAY_W-1:0] last_victim;
  int               words_sent;
  int               mismatches;
  int               src_idle_pct;
  int               dst_idle_pct;

  always #5 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic void reset_model();
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < WAYS; w++)
        lru_rank[s][w] = WAY_W'(w);
    duel_selector = '0;
    miss_count    = 0;
    victim_lfsr   = dsdr_pkg::LFSR_SEED;
    cur_mode      = dsdr_pkg::MODE_RESET;
    cur_bipf      = dsdr_pkg::BIPF_RESET;
  endfunction

  function automatic set_kind_e kind_of(input logic [SET_W-1:0] s);
    logic [SET_W-1:0] group;
    group = s >> DUEL_SHIFT;
    if (group == (s & DUEL_MASK)) return DEDICATED_LRU;
    if (group == (~s & DUEL_MASK)) return DEDICATED_BIP;
    return FOLLOWER;
  endfunction

  function automatic void move_to_mru(input logic [SET_W-1:0] s, input logic [WAY_W-1:0] w);
    logic [WAY_W-1:0] cur;
    cur = lru_rank[s][w];
    for (int i = 0; i < WAYS; i++)
      if (lru_rank[s][i] < cur) lru_rank[s][i]++;
    lru_rank[s][w] = '0;
  endfunction

  function automatic logic [WAY_W-1:0] lru_way(input logic [SET_W-1:0] s);
    for (int i = 0; i < WAYS; i++)
      if (lru_rank[s][i] == WAYS - 1) return WAY_W'(i);
    return '0;
  endfunction

  // bimodal insertion: a miss goes to MRU only when the counter hits the
  // frequency; a hit promotes only the line sitting at the LRU end
  function automatic void bimodal_update(input logic [SET_W-1:0] s,
                                         input logic [WAY_W-1:0] w, input logic h);
    if (!h) begin
      if (miss_count == cur_bipf) begin
        miss_count = 0;
        move_to_mru(s, w);
      end
    end else if (lru_rank[s][w] == WAYS - 1) begin
      move_to_mru(s, w);
    end
  endfunction

  function automatic victim_word_t predict_access(input logic [OP_W-1:0] op,
      input logic [SET_W-1:0] s, input logic [WAY_W-1:0] w, input logic h);
    victim_word_t res;
    res.follower_uses_bip = duel_selector[SELECTOR_BITS-1];
    res.victim_way        = '0;
    if (op == dsdr_pkg::OP_QUERY) begin
      if (cur_mode == dsdr_pkg::MODE_RANDOM) begin
        victim_lfsr    = (victim_lfsr >> 1) ^ (victim_lfsr[0] ? dsdr_pkg::LFSR_TAPS : '0);
        res.victim_way = WAY_W'(victim_lfsr % WAYS);
      end else begin
        res.victim_way = lru_way(s);
      end
      return res;
    end
    if (32'(w) >= WAYS) return res;
    if (cur_mode == dsdr_pkg::MODE_RANDOM) return res;
    if (cur_mode != dsdr_pkg::MODE_DIP) begin
      move_to_mru(s, w);
      return res;
    end
    if (!h) begin
      miss_count++;
      if (miss_count > cur_bipf) miss_count = 0;
      miss_count &= 63;
    end
    case (kind_of(s))
      DEDICATED_LRU: begin
        move_to_mru(s, w);
        if (!h && duel_selector != SEL_MAX) duel_selector++;
      end
      DEDICATED_BIP: begin
        if (!h && duel_selector != '0) duel_selector--;
        bimodal_update(s, w, h);
      end
      default: begin
        if (duel_selector[SELECTOR_BITS-1]) bimodal_update(s, w, h);
        else move_to_mru(s, w);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_responses
    victim_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_victims.size() == 0) begin
        report_mismatch("word with none pending", int'(rsp_ch.victim_way), 0);
      end else begin
        want = pending_victims.pop_front();
        if (rsp_ch.victim_way !== want.victim_way)
          report_mismatch("victim_way", int'(rsp_ch.victim_way), int'(want.victim_way));
        if (rsp_ch.follower_uses_bip !== want.follower_uses_bip)
          report_mismatch("follower_uses_bip", int'(rsp_ch.follower_uses_bip),
                          int'(want.follower_uses_bip));
      end
    end
  end

  always @(posedge clk) rsp_ch.ready <= ($urandom_range(99) >= dst_idle_pct);

  // ---------------------------------------------------------------- drivers

  task automatic write_reg(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (a == ADDR_POLICY_MODE) cur_mode = d[MODE_W-1:0];
    else if (a == ADDR_BIP_FREQ) cur_bipf = d[BIPF_W-1:0];
  endtask

  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [BIPF_W-1:0] bipf);
    write_reg(ADDR_POLICY_MODE, APB_DATA_W'(mode));
    write_reg(ADDR_BIP_FREQ, APB_DATA_W'(bipf));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // updates leave no word behind, so let the last one retire before moving on
  task automatic wait_idle();
    while (pending_victims.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_word(input logic [OP_W-1:0] op, input logic [SET_W-1:0] s,
      input logic [WAY_W-1:0] w, input logic h, input bit known = 0,
      input victim_word_t want = '0);
    victim_word_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.set_index <= s;
    req_ch.way       <= w;
    req_ch.hit       <= h;
    do @(posedge clk); while (!req_ch.ready);
    pred        = predict_access(op, s, w, h);
    last_victim = pred.victim_way;
    if (op == dsdr_pkg::OP_QUERY) pending_victims.push_back(known ? want : pred);
    words_sent++;
    if (words_sent < 545) begin
      src_idle_pct = 14;
      dst_idle_pct = 57;
    end else if (words_sent < 1090) begin
      src_idle_pct = 57;
      dst_idle_pct = 14;
    end else begin
      src_idle_pct = 0;
      dst_idle_pct = 0;
    end
  endtask

  // a miss as the cache issues it: victim query, then fill of that victim
  task automatic miss_fill(input logic [SET_W-1:0] s);
    send_word(dsdr_pkg::OP_QUERY, s, WAY_W'($urandom_range(WAYS - 1)),
              1'($urandom_range(1)));
    send_word(dsdr_pkg::OP_UPDATE, s, last_victim, 1'b0);
  endtask

  // ---------------------------------------------------------------- traffic

  function automatic logic [SET_W-1:0] dedicated_set(input set_kind_e kind);
    logic [SET_W-1:0] grp;
    grp = SET_W'($urandom_range(int'(DUEL_MASK)));
    if (kind == DEDICATED_LRU) return (grp << DUEL_SHIFT) | grp;
    return (grp << DUEL_SHIFT) | (~grp & DUEL_MASK);
  endfunction

  function automatic logic [SET_W-1:0] pick_set();
    case ($urandom_range(9))
      0, 1, 2: return dedicated_set(DEDICATED_LRU);
      3, 4:    return dedicated_set(DEDICATED_BIP);
      8, 9:    return SET_W'($urandom_range(NUM_SETS - 1));
      default: return follower_pool[$urandom_range(7)];
    endcase
  endfunction

  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [BIPF_W-1:0] bipf,
                           input int n, input drift_e drift);
    int               start;
    int               pick;
    bit               pushing;
    logic [SET_W-1:0] s;
    req_ch.valid <= 1'b0;
    wait_idle();
    set_config(mode, bipf);
    start = words_sent;
    while (words_sent - start < n) begin
      pushing = (drift == DRIFT_UP && duel_selector < PUSH_TARGET) ||
                (drift == DRIFT_DOWN && duel_selector != '0);
      if (pushing) begin
        // steer the selector with misses on one dedicated kind
        s = dedicated_set(drift == DRIFT_UP ? DEDICATED_LRU : DEDICATED_BIP);
        if ($urandom_range(3) == 0) miss_fill(s);
        else send_word(dsdr_pkg::OP_UPDATE, s, WAY_W'($urandom_range(WAYS - 1)), 1'b0);
      end else begin
        s    = pick_set();
        pick = $urandom_range(99);
        if (pick < 55) begin
          miss_fill(s);
        end else if (pick < 70) begin
          send_word(dsdr_pkg::OP_UPDATE, s, WAY_W'($urandom_range(WAYS - 1)), 1'b1);
        end else if (pick < 85) begin
          send_word(dsdr_pkg::OP_UPDATE, s, lru_way(s), 1'b1);
        end else if (pick < 93) begin
          send_word(dsdr_pkg::OP_QUERY, s, WAY_W'($urandom_range(WAYS - 1)),
                    1'($urandom_range(1)));
        end else begin
          send_word(dsdr_pkg::OP_UPDATE, s, WAY_W'($urandom_range(WAYS - 1)),
                    1'($urandom_range(1)));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- directed

  function automatic void cfg_row(input logic [MODE_W-1:0] mode, input logic [BIPF_W-1:0] bipf);
    stim_row_t r;
    r      = '{kind: ROW_CFG, default: '0};
    r.mode = mode;
    r.bipf = bipf;
    directed_rows.push_back(r);
  endfunction

  function automatic void word_row(input logic [OP_W-1:0] op, input logic [SET_W-1:0] s,
      input logic [WAY_W-1:0] w, input logic h, input bit known = 0,
      input logic [WAY_W-1:0] victim = '0);
    stim_row_t r;
    r         = '{kind: ROW_WORD, default: '0};
    r.op      = op;
    r.set_idx = s;
    r.way     = w;
    r.hit     = h;
    r.known   = known;
    r.want    = {victim, 1'b0};
    directed_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    // fresh stacks: way 15 sits at the LRU end
    word_row(dsdr_pkg::OP_QUERY, 10'd0, 4'd0, 1'b0, 1, 4'd15);
    word_row(dsdr_pkg::OP_QUERY, 10'd1023, 4'd15, 1'b1, 1, 4'd15);
    word_row(dsdr_pkg::OP_UPDATE, 10'd0, 4'd15, 1'b1);
    word_row(dsdr_pkg::OP_QUERY, 10'd0, 4'd0, 1'b0, 1, 4'd14);
    word_row(dsdr_pkg::OP_UPDATE, 10'd1023, 4'd0, 1'b0);
    word_row(dsdr_pkg::OP_QUERY, 10'd1023, 4'd0, 1'b0);
    word_row(dsdr_pkg::OP_UPDATE, 10'd512, 4'd7, 1'b1);
    word_row(dsdr_pkg::OP_QUERY, 10'd512, 4'd0, 1'b0);
    // LFSR from seed: 0xB400 then 0x5A00, both give way 0
    cfg_row(dsdr_pkg::MODE_RANDOM, dsdr_pkg::BIPF_RESET);
    word_row(dsdr_pkg::OP_QUERY, 10'd0, 4'd0, 1'b0, 1, 4'd0);
    word_row(dsdr_pkg::OP_QUERY, 10'd5, 4'd0, 1'b0, 1, 4'd0);
    word_row(dsdr_pkg::OP_UPDATE, 10'd0, 4'd3, 1'b0);
    word_row(dsdr_pkg::OP_QUERY, 10'd0, 4'd0, 1'b0);
    cfg_row(MODE_LRU_ALIAS, dsdr_pkg::BIPF_RESET);
    word_row(dsdr_pkg::OP_UPDATE, 10'd0, 4'd14, 1'b1);
    word_row(dsdr_pkg::OP_QUERY, 10'd0, 4'd0, 1'b0);
    // dueling: LRU set 17, BIP set 30, follower 1000
    cfg_row(dsdr_pkg::MODE_DIP, 6'd1);
    word_row(dsdr_pkg::OP_UPDATE, 10'd17, 4'd2, 1'b0);
    word_row(dsdr_pkg::OP_QUERY, 10'd17, 4'd0, 1'b0);
    word_row(dsdr_pkg::OP_UPDATE, 10'd30, 4'd15, 1'b1);
    word_row(dsdr_pkg::OP_QUERY, 10'd30, 4'd0, 1'b0);
    word_row(dsdr_pkg::OP_UPDATE, 10'd30, 4'd3, 1'b0);
    word_row(dsdr_pkg::OP_UPDATE, 10'd30, 4'd4, 1'b0);
    word_row(dsdr_pkg::OP_QUERY, 10'd30, 4'd0, 1'b0);
    word_row(dsdr_pkg::OP_UPDATE, 10'd1000, 4'd5, 1'b0);
    word_row(dsdr_pkg::OP_QUERY, 10'd1000, 4'd0, 1'b0);
    cfg_row(dsdr_pkg::MODE_DIP, 6'd63);
    word_row(dsdr_pkg::OP_UPDATE, 10'd255, 4'd9, 1'b1);
    word_row(dsdr_pkg::OP_QUERY, 10'd255, 4'd0, 1'b0);
  endfunction

  // ---------------------------------------------------------------- main

  initial begin : stimulus
    logic [SET_W-1:0] s;
    clk              = 1'b0;
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.operation = dsdr_pkg::OP_QUERY;
    req_ch.set_index = '0;
    req_ch.way       = '0;
    req_ch.hit       = 1'b0;
    rsp_ch.ready     = 1'b0;
    words_sent       = 0;
    mismatches       = 0;
    src_idle_pct     = 14;
    dst_idle_pct     = 57;
    last_victim      = '0;
    reset_model();
    build_directed();
    foreach (follower_pool[i]) begin
      do s = SET_W'($urandom_range(NUM_SETS - 1)); while (kind_of(s) != FOLLOWER);
      follower_pool[i] = s;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        req_ch.valid <= 1'b0;
        wait_idle();
        set_config(directed_rows[i].mode, directed_rows[i].bipf);
      end else begin
        send_word(directed_rows[i].op, directed_rows[i].set_idx, directed_rows[i].way,
                  directed_rows[i].hit, directed_rows[i].known, directed_rows[i].want);
      end
    end

    run_phase(dsdr_pkg::MODE_LRU, 6'd63, 40, DRIFT_NONE);
    run_phase(dsdr_pkg::MODE_RANDOM, 6'd1, 40, DRIFT_NONE);
    run_phase(MODE_LRU_ALIAS, 6'd0, 20, DRIFT_NONE);
    run_phase(dsdr_pkg::MODE_DIP, 6'd63, 750, DRIFT_UP);
    run_phase(dsdr_pkg::MODE_DIP, 6'd1, 700, DRIFT_DOWN);
    run_phase(dsdr_pkg::MODE_DIP, 6'd0, 60, DRIFT_NONE);

    req_ch.valid <= 1'b0;
    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- dip_set_dueling_replacement_unit.f -----
rtl/dsdr_pkg.sv
rtl/dsdr_if.sv
rtl/dsdr_cfg.sv
rtl/dsdr_ctrl.sv
rtl/dsdr_dp.sv
rtl/dip_set_dueling_replacement_unit.sv
tb/dip_set_dueling_replacement_unit_tb.sv
